// File: src/vdi_pkg.sv
// Shared types and constants for the vertex deduplication indexer.
// Used by vdi_pos_table and vertex_dedup_indexer_core; depends on nothing.
package vdi_pkg;

   localparam int WORD_W      = 32;
   localparam int POS_W       = 3 * WORD_W;
   localparam int ATTR_W      = 5 * WORD_W;
   localparam int ECHO_W      = POS_W + ATTR_W;
   localparam int VINDEX_W    = 10;
   localparam int REQ_TDATA_W = POS_W + ATTR_W;
   localparam int RSP_PAD_W   = 6;
   localparam int RSP_TDATA_W = VINDEX_W + ECHO_W + RSP_PAD_W;

   // Bit positions inside rsp_tuser.
   localparam int RSP_USER_NEW = 0;
   localparam int RSP_USER_OVF = 1;
   localparam int RSP_USER_W   = 2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

// File: src/vdi_pos_table.sv
// Storage for the distinct vertex positions: one write port, one read port
// with registered read data. Depends on vdi_pkg for the entry width.
module vdi_pos_table #(
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [$clog2(DEPTH)-1:0]               wr_addr,
   input  logic [vdi_pkg::POS_W-1:0]              wr_data,
   input  logic [$clog2(DEPTH)-1:0]               rd_addr,
   output logic [vdi_pkg::POS_W-1:0]              rd_data
);

   logic [vdi_pkg::POS_W-1:0] pos_mem_ff [DEPTH];
   logic [vdi_pkg::POS_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pos_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= pos_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/vertex_dedup_indexer_core.sv
// Vertex deduplication indexer: top level, sequencer and output register;
// depends on vdi_pkg and vdi_pos_table. The wait for a result grows with the
// number of stored entries that the vertex is compared against; one
// comparator fed by one table read a cycle sets this. Synchronous
// active-high reset empties the table and drops any result.

// The block keeps a table of the distinct positions seen so far, in order of
// first appearance. A vertex beat is captured in the idle state; a set
// start_mesh flag empties the table first. The sequencer then walks the table
// from entry zero, issuing one read per cycle. Read data comes back in the
// next cycle and goes through the shared comparator against the captured
// position, so reads and compares overlap. The first match ends the walk.
// When the walk runs past the last stored entry without a match, the
// position is appended (or flagged as overflow when the table is full).
// A done state moves the result into the output register as soon as that
// register is free; the result beat then waits there while the block
// already accepts and works on the next vertex.
module vertex_dedup_indexer_core #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   // Vertex beats.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v (low bit up)
   input  logic [vdi_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // start_mesh
   input  logic [0:0]                        req_tuser,
   // Result beats.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // vertex_index, out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y,
   // out_norm_z, out_tex_u, out_tex_v, six zero bits (low bit up)
   output logic [vdi_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // is_new, overflow (low bit up)
   output logic [vdi_pkg::RSP_USER_W-1:0]    rsp_tuser
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int VIDX_W = vdi_pkg::VINDEX_W;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   vdi_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  addr_ff, addr_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;

   logic [vdi_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [vdi_pkg::ATTR_W-1:0] attr_ff, attr_in;

   logic [IDX_W-1:0]  res_idx_ff, res_idx_in;
   logic              res_new_ff, res_new_in;
   logic              res_ovf_ff, res_ovf_in;

   logic                              rsp_vld_ff, rsp_vld_in;
   logic [vdi_pkg::RSP_TDATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic [vdi_pkg::RSP_USER_W-1:0]    rsp_user_ff, rsp_user_in;

   logic                       wr_en;
   logic [IDX_W-1:0]           rd_addr;
   logic [vdi_pkg::POS_W-1:0]  rd_data;
   logic                       hit;
   logic [vdi_pkg::ECHO_W-1:0] echo;

   vdi_pos_table #(
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (pos_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The shared comparator: the entry read last cycle against the vertex.
   assign hit = cmp_vld_ff && (rd_data == pos_ff);

   // Echo fields are only carried for a vertex that was appended.
   assign echo = res_new_ff ? {attr_ff, pos_ff} : '0;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      addr_in     = addr_ff;
      cmp_vld_in  = cmp_vld_ff;
      cmp_idx_in  = cmp_idx_ff;
      pos_in      = pos_ff;
      attr_in     = attr_ff;
      res_idx_in  = res_idx_ff;
      res_new_in  = res_new_ff;
      res_ovf_in  = res_ovf_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      rsp_user_in = rsp_user_ff;
      wr_en       = 1'b0;
      rd_addr     = addr_ff[IDX_W-1:0];
      req_tready  = 1'b0;

      if (rsp_vld_ff && rsp_tready) begin
         rsp_vld_in = 1'b0;
      end

      unique case (state_ff)
         vdi_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               pos_in     = req_tdata[vdi_pkg::POS_W-1:0];
               attr_in    = req_tdata[vdi_pkg::REQ_TDATA_W-1:vdi_pkg::POS_W];
               addr_in    = '0;
               cmp_vld_in = 1'b0;
               if (req_tuser[0]) begin
                  count_in = '0;
               end
               state_in = vdi_pkg::ST_SCAN;
            end
         end
         vdi_pkg::ST_SCAN: begin
            priority if (hit) begin
               // First match wins: earlier entries already compared unequal.
               res_idx_in = cmp_idx_ff;
               res_new_in = 1'b0;
               res_ovf_in = 1'b0;
               state_in   = vdi_pkg::ST_DONE;
            end else if (addr_ff < count_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = addr_ff[IDX_W-1:0];
               addr_in    = addr_ff + 1'b1;
            end else if (cmp_vld_ff) begin
               // Last read still in flight; wait for its compare.
               cmp_vld_in = 1'b0;
            end else begin
               state_in = vdi_pkg::ST_DONE;
               if (count_ff == DEPTH_CNT) begin
                  res_idx_in = '0;
                  res_new_in = 1'b0;
                  res_ovf_in = 1'b1;
               end else begin
                  wr_en      = 1'b1;
                  res_idx_in = count_ff[IDX_W-1:0];
                  res_new_in = 1'b1;
                  res_ovf_in = 1'b0;
                  count_in   = count_ff + 1'b1;
               end
            end
         end
         vdi_pkg::ST_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = {{vdi_pkg::RSP_PAD_W{1'b0}}, echo, VIDX_W'(res_idx_ff)};
               rsp_user_in = '0;
               rsp_user_in[vdi_pkg::RSP_USER_NEW] = res_new_ff;
               rsp_user_in[vdi_pkg::RSP_USER_OVF] = res_ovf_ff;
               state_in = vdi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = vdi_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= vdi_pkg::ST_IDLE;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      cmp_idx_ff  <= cmp_idx_in;
      pos_ff      <= pos_in;
      attr_ff     <= attr_in;
      res_idx_ff  <= res_idx_in;
      res_new_ff  <= res_new_in;
      res_ovf_ff  <= res_ovf_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   // The table never holds more positions than it has entries.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("unique count exceeds table depth");

   // The walk address never goes beyond the count of stored entries.
   a_scan_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == vdi_pkg::ST_SCAN) |-> (addr_ff <= count_ff))
      else $error("scan address beyond stored entries");

   // A result is never both a new vertex and an overflow.
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> !(rsp_user_ff[vdi_pkg::RSP_USER_NEW] &&
                       rsp_user_ff[vdi_pkg::RSP_USER_OVF]))
      else $error("is_new and overflow both set");

   // Appending a position grows the count by exactly one.
   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (count_ff - 1'b1) == $past(count_ff))
      else $error("append did not advance the unique count");
`endif

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for vertex_dedup_indexer_core: streams vertices in,
// predicts each index and echo beat, and compares every result field.
// Depends on vdi_pkg and the RTL of the block only.
module testbench;

   localparam int TABLE_DEPTH  = 1024;
   localparam int WORD_W       = vdi_pkg::WORD_W;
   localparam int POS_W        = vdi_pkg::POS_W;
   localparam int VINDEX_W     = vdi_pkg::VINDEX_W;
   localparam int REQ_TDATA_W  = vdi_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W  = vdi_pkg::RSP_TDATA_W;
   localparam int RSP_PAD_W    = vdi_pkg::RSP_PAD_W;
   localparam int RSP_USER_W   = vdi_pkg::RSP_USER_W;
   localparam int RSP_USER_NEW = vdi_pkg::RSP_USER_NEW;
   localparam int RSP_USER_OVF = vdi_pkg::RSP_USER_OVF;

   // One vertex as it travels on the request stream. words[0] is pos_x and
   // words[7] is tex_v, so the packed array lines up with req_tdata.
   typedef struct packed {
      logic                        start_mesh;
      logic [7:0][WORD_W-1:0]      words;
   } vertex_type;

   // One expected result beat, with the echo words in request order.
   typedef struct packed {
      logic [VINDEX_W-1:0]         vertex_index;
      logic                        is_new;
      logic                        overflow;
      logic [7:0][WORD_W-1:0]      echo;
   } vertex_result_type;

   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v (low bit up)
   logic [REQ_TDATA_W-1:0]  req_tdata  = '0;
   // start_mesh
   logic [0:0]              req_tuser  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   // vertex_index, eight echo words, six zero bits (low bit up)
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   // is_new, overflow (low bit up)
   logic [RSP_USER_W-1:0]   rsp_tuser;

   vertex_dedup_indexer_core #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Predictor state: the distinct positions of the current mesh, in order
   // of first appearance, and how many of them are valid.
   logic [POS_W-1:0]        seen_positions [TABLE_DEPTH];
   int                      seen_count = 0;

   // Results predicted at request acceptance, oldest first.
   vertex_result_type       expected_results [$];

   int                      error_count = 0;
   int                      result_serial = 0;

   // Idle percentages for both sides. The receiver side is read by the
   // receive process, so it is only ever changed with nonblocking writes.
   int                      send_idle_pct = 0;
   int                      recv_stall_pct = 0;

   // Long receiver hold-off: the test toggles hold_go, the receive process
   // notices the change and holds tready low itself while hold_left counts down.
   logic                    hold_go = 1'b0;
   logic                    hold_seen = 1'b0;
   int                      hold_len = 0;
   int                      hold_left = 0;

   string echo_names [8] = '{"pos_x", "pos_y", "pos_z", "norm_x", "norm_y",
                             "norm_z", "tex_u", "tex_v"};

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Generous hard stop; the slowest legal run, which fills the whole table
   // once, stays well below this.
   initial begin
      #30_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Works out the result of one accepted vertex and advances the predictor.
   // A start flag empties the table first, a stored position reports its
   // lowest index, and a new position is either appended or flagged as
   // overflow when the table has no room left.
   function automatic vertex_result_type predict_vertex(input vertex_type v);
      vertex_result_type r;
      logic [POS_W-1:0]  pos;
      bit                found;
      r     = '0;
      pos   = {v.words[2], v.words[1], v.words[0]};
      found = 1'b0;
      if (v.start_mesh)
         seen_count = 0;
      for (int i = 0; i < seen_count && !found; i++) begin
         if (seen_positions[i] == pos) begin
            found          = 1'b1;
            r.vertex_index = VINDEX_W'(i);
         end
      end
      if (!found) begin
         if (seen_count >= TABLE_DEPTH) begin
            r.overflow = 1'b1;
         end else begin
            r.vertex_index             = VINDEX_W'(seen_count);
            r.is_new                   = 1'b1;
            r.echo                     = v.words;
            seen_positions[seen_count] = pos;
            seen_count++;
         end
      end
      return r;
   endfunction

   function automatic vertex_type make_vertex(input bit start, input logic [31:0] x,
                                              input logic [31:0] y, input logic [31:0] z,
                                              input logic [31:0] attr);
      vertex_type v;
      v.start_mesh = start;
      v.words[0]   = x;
      v.words[1]   = y;
      v.words[2]   = z;
      for (int k = 3; k < 8; k++)
         v.words[k] = attr;
      return v;
   endfunction

   function automatic vertex_type random_attrs(input bit start,
                                               input logic [POS_W-1:0] pos);
      vertex_type v;
      v.start_mesh = start;
      v.words[0]   = pos[31:0];
      v.words[1]   = pos[63:32];
      v.words[2]   = pos[95:64];
      for (int k = 3; k < 8; k++)
         v.words[k] = $urandom;
      return v;
   endfunction

   // Offers one vertex beat, with random idle cycles ahead of it, and holds
   // it until the block takes it. The expectation is recorded at the edge
   // that accepts the beat.
   task automatic send_vertex(input vertex_type v);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v.words;
      req_tuser  <= v.start_mesh;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      expected_results.push_back(predict_vertex(v));
   endtask

   // Lowers the request valid and waits until every predicted beat is back.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do
         @(posedge clock);
      while (expected_results.size() != 0);
   endtask

   task automatic note_failure(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
      error_count++;
      if (error_count <= 10)
         $display("result %0d: %s expected %h, got %h", result_serial, what, exp_v, act_v);
   endtask

   task automatic compare_field(input string what, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
      if (exp_v !== act_v)
         note_failure(what, exp_v, act_v);
   endtask

   // Compares one accepted result beat, field by field, with the oldest
   // expectation. A beat with nothing waiting is a failure of its own.
   task automatic check_result();
      vertex_result_type exp_r;
      if (expected_results.size() == 0) begin
         note_failure("unexpected beat, index", '0, 32'(rsp_tdata[VINDEX_W-1:0]));
      end else begin
         exp_r = expected_results.pop_front();
         compare_field("vertex_index", 32'(exp_r.vertex_index),
                       32'(rsp_tdata[VINDEX_W-1:0]));
         compare_field("is_new", 32'(exp_r.is_new), 32'(rsp_tuser[RSP_USER_NEW]));
         compare_field("overflow", 32'(exp_r.overflow), 32'(rsp_tuser[RSP_USER_OVF]));
         for (int k = 0; k < 8; k++)
            compare_field(echo_names[k], exp_r.echo[k],
                          rsp_tdata[VINDEX_W + k*WORD_W +: WORD_W]);
         compare_field("pad", '0, 32'(rsp_tdata[RSP_TDATA_W-1 -: RSP_PAD_W]));
      end
      result_serial++;
   endtask

   // Receive side: checks the beat taken at this edge, then decides tready
   // for the next cycle, either from the hold-off count or at random.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_result();
      if (hold_go != hold_seen) begin
         hold_seen  <= hold_go;
         hold_left  <= hold_len;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Extremes of the position words, bitwise equality on each of the three
   // words, repeats, and the start flag both on a stored and on an unknown
   // position.
   task automatic test_directed();
      send_vertex(make_vertex(1'b1, '0, '0, '0, '0));
      send_vertex(make_vertex(1'b0, '0, '0, '0, '1));
      send_vertex(make_vertex(1'b0, '1, '1, '1, '1));
      send_vertex(make_vertex(1'b0, '1, '1, '0, '0));
      send_vertex(make_vertex(1'b0, '0, '1, '1, 32'h5555_aaaa));
      send_vertex(make_vertex(1'b0, '1, '0, '1, 32'haaaa_5555));
      send_vertex(make_vertex(1'b0, 32'h1, '0, '0, '1));
      send_vertex(make_vertex(1'b0, 32'h8000_0000, '0, '0, '0));
      send_vertex(make_vertex(1'b0, '0, 32'h8000_0000, '0, '1));
      send_vertex(make_vertex(1'b0, '0, '0, 32'h1, '0));
      send_vertex(make_vertex(1'b0, '1, '1, '1, '0));
      send_vertex(make_vertex(1'b0, 32'h1, '0, '0, '0));
      // Start flag on a position that is stored: it must come back as new.
      send_vertex(make_vertex(1'b1, '1, '1, '1, '0));
      send_vertex(make_vertex(1'b1, '1, '1, '1, '1));
      send_vertex(make_vertex(1'b0, '0, '0, '0, '1));
      send_vertex(make_vertex(1'b0, '1, '1, '1, 32'h0f0f_f0f0));
      send_vertex(make_vertex(1'b0, '0, '0, '0, '0));
      wait_for_results();
   endtask

   // Fills every entry of the table, hits the last index, then offers new
   // positions that must overflow while stored ones still resolve.
   task automatic test_table_fill();
      logic [POS_W-1:0] fill_pos [TABLE_DEPTH];
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         fill_pos[i] = {32'(i), $urandom(), $urandom()};
         send_vertex(random_attrs(i == 0, fill_pos[i]));
      end
      send_vertex(random_attrs(1'b0, fill_pos[TABLE_DEPTH-1]));
      send_vertex(random_attrs(1'b0, fill_pos[0]));
      send_vertex(random_attrs(1'b0, {32'd5000, $urandom(), $urandom()}));
      send_vertex(make_vertex(1'b0, '1, '1, '1, '1));
      send_vertex(random_attrs(1'b0, fill_pos[TABLE_DEPTH/2]));
      send_vertex(make_vertex(1'b0, '0, '0, 32'd2000, '0));
      wait_for_results();
   endtask

   // The receiver holds off for a long stretch while the sender keeps
   // offering beats, so the output register and the sequencer both fill up
   // and the block has to stall its request side.
   task automatic test_backpressure();
      logic [POS_W-1:0] pos;
      send_idle_pct  = 0;
      recv_stall_pct <= 0;
      hold_len       <= 400;
      hold_go        <= ~hold_go;
      for (int i = 0; i < 24; i++) begin
         if (i % 4 == 3)
            pos = {32'(i - 3), 32'h0, 32'h0};
         else
            pos = {32'(i), $urandom(), 32'h0};
         send_vertex(random_attrs(i == 0, pos));
      end
      wait_for_results();
   endtask

   // Random meshes. Most positions are built from a few coordinate words per
   // mesh, so full repeats and near misses in one word are frequent; the
   // rest are repeats drawn from the mesh so far or fully random positions.
   // A stray start flag now and then cuts a mesh short.
   task automatic test_random_meshes(input int item_count, input int send_pct,
                                     input int recv_pct);
      logic [31:0]      coord_pool [3][3];
      logic [POS_W-1:0] mesh_history [$];
      logic [POS_W-1:0] pos;
      int               sent;
      int               mesh_len;
      int               pick;
      send_idle_pct  = send_pct;
      recv_stall_pct <= recv_pct;
      sent           = 0;
      while (sent < item_count) begin
         if ($urandom_range(9) == 0)
            mesh_len = $urandom_range(200, 60);
         else
            mesh_len = $urandom_range(40, 1);
         for (int c = 0; c < 3; c++)
            for (int k = 0; k < 3; k++)
               coord_pool[c][k] = $urandom;
         mesh_history.delete();
         for (int k = 0; k < mesh_len && sent < item_count; k++) begin
            pick = $urandom_range(99);
            if (pick < 20 && mesh_history.size() > 0)
               pos = mesh_history[$urandom_range(mesh_history.size() - 1)];
            else if (pick < 35)
               pos = {$urandom(), $urandom(), $urandom()};
            else
               pos = {coord_pool[2][$urandom_range(2)], coord_pool[1][$urandom_range(2)],
                      coord_pool[0][$urandom_range(2)]};
            mesh_history.push_back(pos);
            send_vertex(random_attrs(k == 0 || pick >= 98, pos));
            sent++;
         end
      end
      wait_for_results();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_table_fill();
      test_backpressure();
      test_random_meshes(150, 0, 0);
      test_random_meshes(145, 47, 0);
      test_random_meshes(145, 0, 47);
      test_random_meshes(140, 37, 37);

      // Give any stray beat a full table walk to show up before judging.
      recv_stall_pct <= 0;
      repeat (TABLE_DEPTH + 16) @(posedge clock);
      if (error_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
